// ----- rtl/core/lt_pkg.sv -----
// line tokenizer package: token kinds, error codes, lexer modes, result types
// no dependencies
`default_nettype none
package lt_pkg;

  localparam logic [2:0] K_STR   = 3'd0;
  localparam logic [2:0] K_OP    = 3'd1;
  localparam logic [2:0] K_INT   = 3'd2;
  localparam logic [2:0] K_IDENT = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;
  localparam logic [2:0] K_OK    = 3'd5;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNTERM   = 3'd1;
  localparam logic [2:0] E_ESCAPE   = 3'd2;
  localparam logic [2:0] E_RANGE    = 3'd3;
  localparam logic [2:0] E_UNEXPECT = 3'd4;

  localparam logic [30:0] INT_LIMIT = 31'h7fff_ffff;
  localparam int          MAX_RES   = 4;
  localparam int          QDEPTH    = 4;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b00_0000_0001,
    M_IDENT   = 10'b00_0000_0010,
    M_NUM     = 10'b00_0000_0100,
    M_STR     = 10'b00_0000_1000,
    M_STR_ESC = 10'b00_0001_0000,
    M_EQ      = 10'b00_0010_0000,
    M_BANG    = 10'b00_0100_0000,
    M_SLASH   = 10'b00_1000_0000,
    M_SKIP    = 10'b01_0000_0000,
    M_STOP    = 10'b10_0000_0000
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_res;
    logic        byte_valid;
    logic        tok_start;
    logic        tok_end;
    logic [30:0] int_value;
    logic [2:0]  error_code;
    logic        line_done;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [2:0]         cnt;
  } bundle_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b, logic bv, logic st,
                                  logic en, logic [30:0] iv, logic [2:0] err);
    res_t x;
    x.kind       = kind;
    x.byte_res   = b;
    x.byte_valid = bv;
    x.tok_start  = st;
    x.tok_end    = en;
    x.int_value  = iv;
    x.error_code = err;
    x.line_done  = 1'b0;
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lt_if.sv -----
// channel interfaces for the line tokenizer
// no dependencies
`default_nettype none
interface lt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       line_end;
  modport source (output valid, ch, has_char, line_end, input ready);
  modport sink   (input valid, ch, has_char, line_end, output ready);
endinterface

interface lt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_res;
  logic        byte_valid;
  logic        tok_start;
  logic        tok_end;
  logic [30:0] int_value;
  logic [2:0]  error_code;
  logic        line_done;
  modport source (output valid, kind, byte_res, byte_valid, tok_start, tok_end, int_value,
                  error_code, line_done, input ready);
  modport sink   (input valid, kind, byte_res, byte_valid, tok_start, tok_end, int_value,
                  error_code, line_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lt_front.sv -----
// front end: accepts characters, runs the lexer state, builds result bundles
// depends on lt_pkg, lt_if
`default_nettype none
module lt_front
  import lt_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  lt_in_if.sink      in_chan,
  input  wire        q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  mode_t       mode_r, mode_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        ov_r, ov_nxt;
  logic        es_r, es_nxt;
  logic [7:0]  ec_r, ec_nxt;
  logic        acc_go;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  assign in_chan.ready = !q_full;
  assign acc_go        = in_chan.valid && in_chan.ready;

  always_comb begin
    logic [7:0]  c;
    logic [2:0]  n;
    logic        fresh;
    logic [34:0] prod;
    res_t [MAX_RES-1:0] r;
    c        = in_chan.ch;
    n        = 3'd0;
    fresh    = 1'b0;
    r        = '0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    ov_nxt   = ov_r;
    es_nxt   = es_r;
    ec_nxt   = ec_r;
    prod     = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {31'd0, c[3:0]};
    if (in_chan.has_char) begin
      unique case (mode_r)
        M_STOP, M_SKIP: ;
        M_STR: begin
          if (c == "\"") begin
            if (es_r) begin
              r[n[1:0]] = mk_res(K_ERR, ec_r, 1'b1, 1'b0, 1'b0, '0, E_ESCAPE);
              mode_nxt = M_STOP;
            end else begin
              r[n[1:0]] = mk_res(K_STR, 8'd0, 1'b0, 1'b0, 1'b1, '0, E_NONE);
              mode_nxt = M_IDLE;
            end
            n = n + 3'd1;
          end else if (c == "\\") begin
            mode_nxt = M_STR_ESC;
          end else begin
            r[n[1:0]] = mk_res(K_STR, c, 1'b1, 1'b0, 1'b0, '0, E_NONE);
            n = n + 3'd1;
          end
        end
        M_STR_ESC: begin
          mode_nxt = M_STR;
          if (c == "n" || c == "t" || c == "r" || c == "\\" || c == "\"") begin
            r[n[1:0]] = mk_res(K_STR, (c == "n") ? 8'h0a : (c == "t") ? 8'h09 :
                               (c == "r") ? 8'h0d : c, 1'b1, 1'b0, 1'b0, '0, E_NONE);
            n = n + 3'd1;
          end else if (!es_r) begin
            es_nxt = 1'b1;
            ec_nxt = c;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            r[n[1:0]] = mk_res(K_IDENT, c, 1'b1, 1'b0, 1'b0, '0, E_NONE);
          end else begin
            r[n[1:0]] = mk_res(K_IDENT, 8'd0, 1'b0, 1'b0, 1'b1, '0, E_NONE);
            fresh = 1'b1;
          end
          n = n + 3'd1;
        end
        M_NUM: begin
          if (is_digit(c)) begin
            if (prod > {4'd0, INT_LIMIT}) begin
              ov_nxt  = 1'b1;
              acc_nxt = INT_LIMIT;
            end else begin
              acc_nxt = prod[30:0];
            end
            r[n[1:0]] = mk_res(K_INT, c, 1'b1, 1'b0, 1'b0, '0, E_NONE);
          end else if (ov_r) begin
            r[n[1:0]] = mk_res(K_ERR, 8'd0, 1'b0, 1'b0, 1'b0, '0, E_RANGE);
            mode_nxt = M_STOP;
          end else begin
            r[n[1:0]] = mk_res(K_INT, 8'd0, 1'b0, 1'b0, 1'b1, acc_r, E_NONE);
            fresh = 1'b1;
          end
          n = n + 3'd1;
        end
        M_EQ, M_BANG: begin
          if (c == "=") begin
            r[0] = mk_res(K_OP, (mode_r == M_EQ) ? "=" : "!", 1'b1, 1'b1, 1'b0, '0, E_NONE);
            r[1] = mk_res(K_OP, "=", 1'b1, 1'b0, 1'b1, '0, E_NONE);
            n = 3'd2;
            mode_nxt = M_IDLE;
          end else if (mode_r == M_EQ) begin
            r[0] = mk_res(K_OP, "=", 1'b1, 1'b1, 1'b1, '0, E_NONE);
            n = 3'd1;
            fresh = 1'b1;
          end else begin
            r[0] = mk_res(K_ERR, "!", 1'b1, 1'b0, 1'b0, '0, E_UNEXPECT);
            n = 3'd1;
            mode_nxt = M_STOP;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_nxt = M_SKIP;
          end else begin
            r[0] = mk_res(K_OP, "/", 1'b1, 1'b1, 1'b1, '0, E_NONE);
            n = 3'd1;
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
    end
    if (fresh) begin
      mode_nxt = M_IDLE;
      if (c == " " || c == 8'h09 || c == 8'h0d) begin
      end else if (c == "#") begin
        mode_nxt = M_SKIP;
      end else if (c == "\"") begin
        r[n[1:0]] = mk_res(K_STR, 8'd0, 1'b0, 1'b1, 1'b0, '0, E_NONE);
        n = n + 3'd1;
        es_nxt = 1'b0;
        ec_nxt = 8'd0;
        mode_nxt = M_STR;
      end else if (c == "=") begin
        mode_nxt = M_EQ;
      end else if (c == "!") begin
        mode_nxt = M_BANG;
      end else if (c == "/") begin
        mode_nxt = M_SLASH;
      end else if (c == "+" || c == "-" || c == "*") begin
        r[n[1:0]] = mk_res(K_OP, c, 1'b1, 1'b1, 1'b1, '0, E_NONE);
        n = n + 3'd1;
      end else if (is_digit(c)) begin
        acc_nxt = {27'd0, c[3:0]};
        ov_nxt  = 1'b0;
        r[n[1:0]] = mk_res(K_INT, c, 1'b1, 1'b1, 1'b0, '0, E_NONE);
        n = n + 3'd1;
        mode_nxt = M_NUM;
      end else if (is_alpha(c) || c == "_") begin
        r[n[1:0]] = mk_res(K_IDENT, c, 1'b1, 1'b1, 1'b0, '0, E_NONE);
        n = n + 3'd1;
        mode_nxt = M_IDENT;
      end else begin
        r[n[1:0]] = mk_res(K_ERR, c, 1'b1, 1'b0, 1'b0, '0, E_UNEXPECT);
        n = n + 3'd1;
        mode_nxt = M_STOP;
      end
    end
    if (in_chan.line_end) begin
      unique case (mode_nxt)
        M_IDENT: begin
          r[n[1:0]] = mk_res(K_IDENT, 8'd0, 1'b0, 1'b0, 1'b1, '0, E_NONE);
          n = n + 3'd1;
        end
        M_NUM: begin
          if (ov_nxt) begin
            r[n[1:0]] = mk_res(K_ERR, 8'd0, 1'b0, 1'b0, 1'b0, '0, E_RANGE);
            mode_nxt = M_STOP;
          end else begin
            r[n[1:0]] = mk_res(K_INT, 8'd0, 1'b0, 1'b0, 1'b1, acc_nxt, E_NONE);
          end
          n = n + 3'd1;
        end
        M_EQ, M_SLASH: begin
          r[n[1:0]] = mk_res(K_OP, (mode_nxt == M_EQ) ? "=" : "/", 1'b1, 1'b1, 1'b1, '0,
                             E_NONE);
          n = n + 3'd1;
        end
        M_BANG: begin
          r[n[1:0]] = mk_res(K_ERR, "!", 1'b1, 1'b0, 1'b0, '0, E_UNEXPECT);
          n = n + 3'd1;
          mode_nxt = M_STOP;
        end
        M_STR, M_STR_ESC: begin
          r[n[1:0]] = mk_res(K_ERR, 8'd0, 1'b0, 1'b0, 1'b0, '0, E_UNTERM);
          n = n + 3'd1;
          mode_nxt = M_STOP;
        end
        default: ;
      endcase
      if (mode_nxt != M_STOP) begin
        r[n[1:0]] = mk_res(K_OK, 8'd0, 1'b0, 1'b0, 1'b0, '0, E_NONE);
        n = n + 3'd1;
      end
      if (n != 3'd0) r[n[1:0] - 2'd1].line_done = 1'b1;
      mode_nxt = M_IDLE;
      acc_nxt  = '0;
      ov_nxt   = 1'b0;
      es_nxt   = 1'b0;
      ec_nxt   = 8'd0;
    end
    q_data.r   = r;
    q_data.cnt = n;
    q_push     = acc_go && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      ov_r   <= 1'b0;
      es_r   <= 1'b0;
      ec_r   <= 8'd0;
    end else if (acc_go) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ov_r   <= ov_nxt;
      es_r   <= es_nxt;
      ec_r   <= ec_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lt_queue.sv -----
// short bundle queue between the lexer front end and the result back end
// depends on lt_pkg
`default_nettype none
module lt_queue
  import lt_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      push,
  input  bundle_t  push_data,
  input  wire      pop,
  output logic     full,
  output logic     empty,
  output bundle_t  head
);

  localparam int AW = $clog2(QDEPTH);

  bundle_t       mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lt_back.sv -----
// back end: walks the head bundle and presents one result per request
// depends on lt_pkg, lt_if
`default_nettype none
module lt_back
  import lt_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      empty,
  input  bundle_t  head,
  output logic     pop,
  lt_out_if.source out_chan
);

  logic [1:0] idx_r;
  res_t       cur;
  logic       last;

  assign cur  = head.r[idx_r];
  assign last = ({1'b0, idx_r} + 3'd1) == head.cnt;
  assign pop  = out_chan.valid && out_chan.ready && last;

  assign out_chan.valid      = !empty;
  assign out_chan.kind       = cur.kind;
  assign out_chan.byte_res   = cur.byte_res;
  assign out_chan.byte_valid = cur.byte_valid;
  assign out_chan.tok_start  = cur.tok_start;
  assign out_chan.tok_end    = cur.tok_end;
  assign out_chan.int_value  = cur.int_value;
  assign out_chan.error_code = cur.error_code;
  assign out_chan.line_done  = cur.line_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_chan.valid && out_chan.ready) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/line_tokenizer_top.sv -----
// line tokenizer top level: front end, bundle queue and back end
// depends on lt_pkg, lt_if, lt_front, lt_queue, lt_back
`default_nettype none
// One character is taken per cycle; the lexer state register updates on each
// accepted character, so input items follow back to back. Each item yields up to
// four results, which are queued (four bundles deep) and delivered one per cycle
// while the output is ready. Input stalls only when the queue is full.
module line_tokenizer_top
  import lt_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  lt_in_if.sink    in_chan,
  lt_out_if.source out_chan
);

  logic    q_push, q_full, q_empty, q_pop;
  bundle_t q_in, q_head;

  lt_front u_front (
    .clk, .rst_n, .in_chan, .q_full, .q_push, .q_data(q_in)
  );

  lt_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
    .full(q_full), .empty(q_empty), .head(q_head)
  );

  lt_back u_back (
    .clk, .rst_n, .empty(q_empty), .head(q_head), .pop(q_pop), .out_chan
  );

endmodule
`default_nettype wire
